>>> design/length_prefix_to_start_code_core_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef LENGTH_PREFIX_TO_START_CODE_CORE_DEFINES_SVH
`define LENGTH_PREFIX_TO_START_CODE_CORE_DEFINES_SVH

`ifndef SYNTH
`define LPSC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LPSC_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define LPSC_ASSERT(name, prop, msg)
`define LPSC_ASSERT_NEXT(name, cond, expr, msg)
`endif

`endif

>>> design/lpsc_pkg.sv
// Types and constants for the length-prefix to start-code converter.
package lpsc_pkg;

    localparam int LPSC_LEN_BITS    = 32;
    localparam int LPSC_QUEUE_DEPTH = 4;

    localparam logic [1:0] MODE_LEN4 = 2'd0;
    localparam logic [1:0] MODE_LEN2 = 2'd1;
    localparam logic [1:0] MODE_RAW  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_TRUNC   = 3'd2;
    localparam logic [2:0] ST_PARTIAL = 3'd3;
    localparam logic [2:0] ST_FORBID  = 3'd4;

    localparam logic [7:0] FORBID_MASK = 8'h80;

    // One queue entry: what a single input byte expands into.
    typedef struct packed {
        logic       start;      // 00 00 00 01 first
        logic       has_byte;   // then the data byte
        logic [7:0] data;
        logic       data_last;
        logic       has_marker; // then an error marker
        logic [2:0] status;
    } lpsc_cmd_t;

endpackage

>>> design/lpsc_if.sv
// Byte stream channels of the converter.
interface lpsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lpsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] status;

    modport source (output valid, output out_byte, output out_last, output status,
                    input ready);
    modport sink (input valid, input out_byte, input out_last, input status,
                  output ready);
endinterface

>>> design/lpsc_front.sv
// Front end: parses length headers and classifies each input byte.
module lpsc_front
    import lpsc_pkg::*;
#(
    parameter int LEN_BITS = LPSC_LEN_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data,
    lpsc_in_if.sink    in_ch,
    input  logic       q_full,
    output logic       q_push,
    output lpsc_cmd_t  q_cmd
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DROP    = 2'd2;
    localparam logic [1:0] PH_RAW     = 2'd3;

    localparam logic [32:0] LEN_MAX = (33'd1 << LEN_BITS) - 33'd1;

    logic [1:0]  mode_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  hcount_reg, hcount_next;
    logic [31:0] remain_reg, remain_next;
    logic [2:0]  err_reg, err_next;

    logic        accept;
    logic        fail_en;
    logic [2:0]  fail_code;
    logic        restart;
    logic [2:0]  hsize;
    logic [31:0] rem_dec;
    logic [31:0] rem_asm;
    logic [31:0] len_sat;
    lpsc_cmd_t   cmd;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign hsize       = (mode_reg == MODE_LEN2) ? 3'd2 : 3'd4;
    assign rem_dec     = remain_reg - {31'd0, (remain_reg != 32'd0)};
    assign rem_asm     = {remain_reg[23:0], in_ch.in_byte};
    assign len_sat     = ({1'b0, rem_asm} > LEN_MAX) ? LEN_MAX[31:0] : rem_asm;

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        remain_next = remain_reg;
        err_next    = err_reg;
        fail_en     = 1'b0;
        fail_code   = ST_OK;
        restart     = 1'b0;
        cmd         = '0;
        cmd.data    = in_ch.in_byte;

        unique case (phase_reg)
            PH_DROP:
            begin
                if (in_ch.in_last)
                begin
                    cmd.has_marker = 1'b1;
                    cmd.status     = err_reg;
                    restart        = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                remain_next  = rem_dec;
                cmd.has_byte = 1'b1;
                if (in_ch.in_last)
                begin
                    cmd.data_last = (rem_dec == 32'd0);
                    if (rem_dec != 32'd0)
                    begin
                        cmd.has_marker = 1'b1;
                        cmd.status     = ST_TRUNC;
                    end
                    restart = 1'b1;
                end
                else if (rem_dec == 32'd0)
                begin
                    phase_next  = PH_HEADER;
                    hcount_next = 2'd0;
                end
            end
            PH_RAW:
            begin
                cmd.has_byte  = 1'b1;
                cmd.data_last = in_ch.in_last;
                restart       = in_ch.in_last;
            end
            PH_HEADER:
            begin
                if (mode_reg[1])
                begin
                    // raw mode; mode 3 aliases it
                    hcount_next = 2'd0;
                    remain_next = 32'd0;
                    if ((in_ch.in_byte & FORBID_MASK) != 8'd0)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ST_FORBID;
                    end
                    else
                    begin
                        cmd.start     = 1'b1;
                        cmd.has_byte  = 1'b1;
                        cmd.data_last = in_ch.in_last;
                        if (in_ch.in_last)
                            restart = 1'b1;
                        else
                            phase_next = PH_RAW;
                    end
                end
                else
                begin
                    remain_next = rem_asm;
                    if (({1'b0, hcount_reg} + 3'd1) >= hsize)
                    begin
                        hcount_next = 2'd0;
                        if (len_sat == 32'd0)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_ZERO;
                        end
                        else if (in_ch.in_last)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ST_TRUNC;
                        end
                        else
                        begin
                            cmd.start   = 1'b1;
                            remain_next = len_sat;
                            phase_next  = PH_PAYLOAD;
                        end
                    end
                    else if (in_ch.in_last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ST_PARTIAL;
                    end
                    else
                    begin
                        hcount_next = hcount_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        if (fail_en)
        begin
            if (in_ch.in_last)
            begin
                cmd.has_marker = 1'b1;
                cmd.status     = fail_code;
                restart        = 1'b1;
            end
            else
            begin
                err_next    = fail_code;
                phase_next  = PH_DROP;
                hcount_next = 2'd0;
                remain_next = 32'd0;
            end
        end

        if (restart)
        begin
            phase_next  = PH_HEADER;
            hcount_next = 2'd0;
            remain_next = 32'd0;
            err_next    = ST_OK;
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.start || cmd.has_byte || cmd.has_marker);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_LEN4;
            phase_reg  <= PH_HEADER;
            hcount_reg <= 2'd0;
            remain_reg <= 32'd0;
            err_reg    <= ST_OK;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (accept)
            begin
                phase_reg  <= phase_next;
                hcount_reg <= hcount_next;
                remain_reg <= remain_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule

>>> design/lpsc_queue.sv
// Short command queue between the front end and the output sequencer.
module lpsc_queue
    import lpsc_pkg::*;
#(
    parameter int DEPTH = LPSC_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lpsc_cmd_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output lpsc_cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    lpsc_cmd_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> design/lpsc_back.sv
// Output sequencer: expands queued commands into output bytes.
module lpsc_back
    import lpsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  lpsc_cmd_t head,
    output logic      pop,
    lpsc_out_if.source out_ch
);

    // positions 0..3 start code, then data byte, then marker
    localparam logic [2:0] POS_SC3    = 3'd3;
    localparam logic [2:0] POS_DATA   = 3'd4;
    localparam logic [2:0] POS_MARKER = 3'd5;
    localparam logic [2:0] POS_DONE   = 3'd7;

    logic [2:0] pos_reg;
    logic       started_reg;
    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       ol_reg;
    logic [2:0] os_reg;

    logic [2:0] first_pos, cur_pos, nxt_pos;
    logic       load;
    logic [7:0] item_byte;
    logic       item_last;
    logic [2:0] item_status;

    always_comb
    begin
        if (head.start)
            first_pos = 3'd0;
        else if (head.has_byte)
            first_pos = POS_DATA;
        else
            first_pos = POS_MARKER;
    end

    assign cur_pos = started_reg ? pos_reg : first_pos;
    assign load    = head_valid && (!ov_reg || out_ch.ready);

    always_comb
    begin
        nxt_pos     = POS_DONE;
        item_byte   = 8'd0;
        item_last   = 1'b0;
        item_status = ST_OK;
        if (cur_pos < POS_SC3)
        begin
            nxt_pos = cur_pos + 3'd1;
        end
        else if (cur_pos == POS_SC3)
        begin
            item_byte = 8'd1;
            if (head.has_byte)
                nxt_pos = POS_DATA;
            else if (head.has_marker)
                nxt_pos = POS_MARKER;
        end
        else if (cur_pos == POS_DATA)
        begin
            item_byte = head.data;
            item_last = head.data_last;
            if (head.has_marker)
                nxt_pos = POS_MARKER;
        end
        else
        begin
            item_last   = 1'b1;
            item_status = head.status;
        end
    end

    assign pop = load && (nxt_pos == POS_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 3'd0;
            started_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                ov_reg      <= 1'b1;
                started_reg <= (nxt_pos != POS_DONE);
                pos_reg     <= nxt_pos;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ob_reg <= item_byte;
            ol_reg <= item_last;
            os_reg <= item_status;
        end
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.out_byte = ob_reg;
    assign out_ch.out_last = ol_reg;
    assign out_ch.status   = os_reg;

endmodule

>>> design/length_prefix_to_start_code_core.sv
// Top level of the length-prefix to start-code converter.
//
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    in_byte[7:0], in_last
//  out_ch    out   valid/ready    out_byte[7:0], out_last, status[2:0]
//  cfg       in    cfg_we         cfg_data[1:0] (prefix_mode)
//
// One input byte per cycle while the queue has room; each byte becomes zero
// to five output bytes, four for a start code, via the single output register.
// The front end keeps taking bytes while the command queue (QUEUE_DEPTH
// entries) has room; the output side stalls on its own behind it.
// First output passes the command queue and then the output register.
// Reset clears the parse state, queue pointers and count, and output valid; mode is 0.
`include "length_prefix_to_start_code_core_defines.svh"

module length_prefix_to_start_code_core
    import lpsc_pkg::*;
#(
    parameter int LEN_BITS    = LPSC_LEN_BITS,
    parameter int QUEUE_DEPTH = LPSC_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data,
    lpsc_in_if.sink    in_ch,
    lpsc_out_if.source out_ch
);

    logic      q_push, q_full, q_pop, q_valid;
    lpsc_cmd_t q_cmd, q_head;

    lpsc_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    lpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    lpsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

    `LPSC_ASSERT(a_marker_ends_packet, (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.out_last && out_ch.out_byte == 8'd0), "error marker must be last and zero")
    `LPSC_ASSERT(a_cmd_not_empty, q_valid |-> (q_head.start || q_head.has_byte || q_head.has_marker), "empty command in queue")
    `LPSC_ASSERT(a_no_push_when_full, (q_full && q_push) |-> !in_ch.ready, "push into full queue")
    `LPSC_ASSERT_NEXT(a_no_phantom_out, (!q_valid && (!out_ch.valid || out_ch.ready)), !out_ch.valid, "output without queued work")

endmodule
